// ===== sv/bsp_pkg.sv =====
// Shared types and constants for the BMP stream pixel unpacker.
// Used by bmp_stream_pixel_unpacker; depends on nothing else.
package bsp_pkg;

  localparam int DIM_W = 14;
  localparam int COORD_WIDTH_DEFAULT = 14;
  localparam int DIB_W = 10;
  localparam int PROD_W = 2 * DIM_W;

  localparam logic [DIM_W-1:0] MAX_IMAGE_DIM_RESET = DIM_W'(10000);
  localparam logic [DIB_W-1:0] MAX_DIB_HEADER_SIZE_RESET = DIB_W'(140);

  localparam logic [7:0] SIG_B = 8'h42;
  localparam logic [7:0] SIG_M = 8'h4D;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [15:0] DEPTH_24 = 16'd24;
  localparam logic [15:0] DEPTH_32 = 16'd32;
  localparam logic [DIB_W:0] FILE_HDR_BYTES = (DIB_W + 1)'(14);
  localparam logic [DIB_W-1:0] MIN_DIB_BYTES = DIB_W'(20);

  // Byte offsets of the header fields within the file.
  localparam logic [5:0] POS_SIG_B = 6'd0;
  localparam logic [5:0] POS_SIG_M = 6'd1;
  localparam logic [5:0] POS_FSIZE_0 = 6'd2;
  localparam logic [5:0] POS_FSIZE_1 = 6'd3;
  localparam logic [5:0] POS_FSIZE_2 = 6'd4;
  localparam logic [5:0] POS_FSIZE_3 = 6'd5;
  localparam logic [5:0] POS_DIB_0 = 6'd14;
  localparam logic [5:0] POS_DIB_1 = 6'd15;
  localparam logic [5:0] POS_DIB_2 = 6'd16;
  localparam logic [5:0] POS_DIB_3 = 6'd17;
  localparam logic [5:0] POS_WIDTH_0 = 6'd18;
  localparam logic [5:0] POS_WIDTH_1 = 6'd19;
  localparam logic [5:0] POS_WIDTH_2 = 6'd20;
  localparam logic [5:0] POS_WIDTH_3 = 6'd21;
  localparam logic [5:0] POS_HEIGHT_0 = 6'd22;
  localparam logic [5:0] POS_HEIGHT_1 = 6'd23;
  localparam logic [5:0] POS_HEIGHT_2 = 6'd24;
  localparam logic [5:0] POS_HEIGHT_3 = 6'd25;
  localparam logic [5:0] POS_DEPTH_0 = 6'd28;
  localparam logic [5:0] POS_DEPTH_1 = 6'd29;
  localparam logic [5:0] POS_COMP_0 = 6'd30;
  localparam logic [5:0] POS_COMP_1 = 6'd31;
  localparam logic [5:0] POS_COMP_2 = 6'd32;
  localparam logic [5:0] POS_COMP_3 = 6'd33;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PIXELS,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ST_PIXEL = 2'd0,
    ST_BAD_SIGNATURE = 2'd1,
    ST_BAD_COMPRESSION = 2'd2,
    ST_BAD_PARAMS = 2'd3
  } status_t;

  typedef enum logic {
    REG_MAX_IMAGE_DIM = 1'b0,
    REG_MAX_DIB_HEADER_SIZE = 1'b1
  } reg_index_t;

  typedef struct packed {
    status_t status;
    logic [DIM_W-1:0] x;
    logic [DIM_W-1:0] y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic last;
  } result_t;

endpackage

// ===== sv/bmp_stream_pixel_unpacker.sv =====
// Top level of the BMP stream pixel unpacker: header parser, pixel unpacker,
// configuration registers and a two-entry result queue. Depends on bsp_pkg.

// The block takes one file byte per clock cycle while item_ready is high, and
// writes the result it causes into the result queue when the byte is accepted.
// A two-entry result queue sits at the output, so bytes keep flowing while one
// result waits; item_ready drops only when both queue entries hold results not
// yet taken. The width*height check uses a registered 14 by 14 bit product that
// is ready well before the last compression byte. Configuration registers
// should be written only while the block is idle.
module bmp_stream_pixel_unpacker #(
  parameter int COORD_WIDTH = bsp_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  logic [7:0]             data_byte,
  input  logic                   first_byte,
  output logic                   result_valid,
  input  logic                   result_ready,
  output logic [1:0]             status,
  output logic [COORD_WIDTH-1:0] pixel_x,
  output logic [COORD_WIDTH-1:0] pixel_y,
  output logic [7:0]             red,
  output logic [7:0]             green,
  output logic [7:0]             blue,
  output logic [7:0]             alpha,
  output logic                   last_pixel
);

  localparam int DIM_W = bsp_pkg::DIM_W;
  localparam int DIB_W = bsp_pkg::DIB_W;
  localparam int PROD_W = bsp_pkg::PROD_W;

  logic [DIM_W-1:0] max_image_dim;
  logic [DIB_W-1:0] max_dib_header_size;
  logic cfg_write;
  bsp_pkg::reg_index_t cfg_sel;

  bsp_pkg::phase_t phase, phase_next;
  logic [31:0] byte_count, byte_count_next;
  logic [31:0] file_size, file_size_next;
  logic [DIB_W-1:0] dib_size, dib_size_next;
  logic dib_big, dib_big_next;
  logic [DIM_W-1:0] image_width, image_width_next;
  logic width_big, width_big_next;
  logic [DIM_W-1:0] image_height, image_height_next;
  logic height_big, height_big_next;
  logic [15:0] bit_depth, bit_depth_next;
  logic comp_nonzero, comp_nonzero_next;
  logic [23:0] pixel_accum, pixel_accum_next;
  logic [1:0] byte_in_pixel, byte_in_pixel_next;
  logic [DIM_W-1:0] column, column_next;
  logic [DIM_W-1:0] row, row_next;
  logic [1:0] pad_left, pad_left_next;
  logic [PROD_W-1:0] area;

  logic accept;
  logic push;
  logic pop;
  bsp_pkg::result_t res;
  bsp_pkg::result_t queue [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;

  assign pready = 1'b1;
  assign cfg_sel = bsp_pkg::reg_index_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (cfg_sel)
      bsp_pkg::REG_MAX_IMAGE_DIM: prdata = 32'(max_image_dim);
      bsp_pkg::REG_MAX_DIB_HEADER_SIZE: prdata = 32'(max_dib_header_size);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_image_dim <= bsp_pkg::MAX_IMAGE_DIM_RESET;
      max_dib_header_size <= bsp_pkg::MAX_DIB_HEADER_SIZE_RESET;
    end else if (cfg_write) begin
      case (cfg_sel)
        bsp_pkg::REG_MAX_IMAGE_DIM: max_image_dim <= pwdata[DIM_W-1:0];
        bsp_pkg::REG_MAX_DIB_HEADER_SIZE: max_dib_header_size <= pwdata[DIB_W-1:0];
        default: ;
      endcase
    end
  end

  assign item_ready = (count != 2'd2);
  assign accept = item_valid && item_ready;
  assign result_valid = (count != 2'd0);
  assign pop = result_valid && result_ready;

  always_ff @(posedge clk) begin
    area <= PROD_W'(image_width) * PROD_W'(image_height);
  end

  always_comb begin
    bsp_pkg::phase_t ph;
    logic [31:0] bc;
    logic [31:0] fsz;
    logic [DIB_W-1:0] dib;
    logic dbig;
    logic [DIM_W-1:0] w;
    logic wbig;
    logic [DIM_W-1:0] h;
    logic hbig;
    logic [15:0] depth;
    logic cnz;
    logic [23:0] acc;
    logic [1:0] bip;
    logic [DIM_W-1:0] col;
    logic [DIM_W-1:0] rw;
    logic [1:0] pad;
    logic [7:0] b;
    logic params_ok;
    logic bpp4;
    logic emit;
    logic [23:0] emit_acc;
    logic [7:0] emit_alpha;

    ph = phase;
    bc = byte_count;
    fsz = file_size;
    dib = dib_size;
    dbig = dib_big;
    w = image_width;
    wbig = width_big;
    h = image_height;
    hbig = height_big;
    depth = bit_depth;
    cnz = comp_nonzero;
    acc = pixel_accum;
    bip = byte_in_pixel;
    col = column;
    rw = row;
    pad = pad_left;
    if (first_byte) begin
      ph = bsp_pkg::PH_HEADER;
      bc = '0;
      fsz = '0;
      dib = '0;
      dbig = 1'b0;
      w = '0;
      wbig = 1'b0;
      h = '0;
      hbig = 1'b0;
      depth = '0;
      cnz = 1'b0;
      acc = '0;
      bip = '0;
      col = '0;
      rw = '0;
      pad = '0;
    end
    b = data_byte;

    phase_next = ph;
    byte_count_next = (&bc) ? bc : bc + 32'd1;
    file_size_next = fsz;
    dib_size_next = dib;
    dib_big_next = dbig;
    image_width_next = w;
    width_big_next = wbig;
    image_height_next = h;
    height_big_next = hbig;
    bit_depth_next = depth;
    comp_nonzero_next = cnz;
    pixel_accum_next = acc;
    byte_in_pixel_next = bip;
    column_next = col;
    row_next = rw;
    pad_left_next = pad;

    params_ok = !wbig && !hbig && (w <= max_image_dim) && (h <= max_image_dim)
      && (32'(area) <= fsz) && !dbig && (dib <= max_dib_header_size)
      && (dib >= bsp_pkg::MIN_DIB_BYTES)
      && (depth == bsp_pkg::DEPTH_24 || depth == bsp_pkg::DEPTH_32);
    bpp4 = (depth == bsp_pkg::DEPTH_32);
    emit = 1'b0;
    emit_acc = acc;
    emit_alpha = bsp_pkg::ALPHA_OPAQUE;
    push = 1'b0;
    res = '0;

    case (ph)
      bsp_pkg::PH_HEADER: begin
        if (bc == 32'(bsp_pkg::POS_SIG_B) && b != bsp_pkg::SIG_B) begin
          push = 1'b1;
          res.status = bsp_pkg::ST_BAD_SIGNATURE;
          phase_next = bsp_pkg::PH_DONE;
        end else if (bc == 32'(bsp_pkg::POS_SIG_M) && b != bsp_pkg::SIG_M) begin
          push = 1'b1;
          res.status = bsp_pkg::ST_BAD_SIGNATURE;
          phase_next = bsp_pkg::PH_DONE;
        end else if (bc[31:6] == '0) begin
          case (bc[5:0])
            bsp_pkg::POS_FSIZE_0: file_size_next[7:0] = b;
            bsp_pkg::POS_FSIZE_1: file_size_next[15:8] = b;
            bsp_pkg::POS_FSIZE_2: file_size_next[23:16] = b;
            bsp_pkg::POS_FSIZE_3: file_size_next[31:24] = b;
            bsp_pkg::POS_DIB_0: dib_size_next[7:0] = b;
            bsp_pkg::POS_DIB_1: begin
              dib_size_next[DIB_W-1:8] = b[DIB_W-9:0];
              dib_big_next = dbig || (b[7:DIB_W-8] != '0);
            end
            bsp_pkg::POS_DIB_2, bsp_pkg::POS_DIB_3: dib_big_next = dbig || (b != '0);
            bsp_pkg::POS_WIDTH_0: image_width_next[7:0] = b;
            bsp_pkg::POS_WIDTH_1: begin
              image_width_next[DIM_W-1:8] = b[DIM_W-9:0];
              width_big_next = wbig || (b[7:DIM_W-8] != '0);
            end
            bsp_pkg::POS_WIDTH_2, bsp_pkg::POS_WIDTH_3: width_big_next = wbig || (b != '0);
            bsp_pkg::POS_HEIGHT_0: image_height_next[7:0] = b;
            bsp_pkg::POS_HEIGHT_1: begin
              image_height_next[DIM_W-1:8] = b[DIM_W-9:0];
              height_big_next = hbig || (b[7:DIM_W-8] != '0);
            end
            bsp_pkg::POS_HEIGHT_2, bsp_pkg::POS_HEIGHT_3: height_big_next = hbig || (b != '0);
            bsp_pkg::POS_DEPTH_0: bit_depth_next[7:0] = b;
            bsp_pkg::POS_DEPTH_1: bit_depth_next[15:8] = b;
            bsp_pkg::POS_COMP_0, bsp_pkg::POS_COMP_1, bsp_pkg::POS_COMP_2,
            bsp_pkg::POS_COMP_3: comp_nonzero_next = cnz || (b != '0);
            default: ;
          endcase
          if (bc[5:0] == bsp_pkg::POS_COMP_3) begin
            if (comp_nonzero_next) begin
              push = 1'b1;
              res.status = bsp_pkg::ST_BAD_COMPRESSION;
              phase_next = bsp_pkg::PH_DONE;
            end else if (!params_ok) begin
              push = 1'b1;
              res.status = bsp_pkg::ST_BAD_PARAMS;
              phase_next = bsp_pkg::PH_DONE;
            end else if (w == '0 || h == '0) begin
              phase_next = bsp_pkg::PH_DONE;
            end else begin
              phase_next = bsp_pkg::PH_PIXELS;
            end
          end
        end
      end
      bsp_pkg::PH_PIXELS: begin
        if (bc < 32'({1'b0, dib} + bsp_pkg::FILE_HDR_BYTES)) begin
          byte_in_pixel_next = bip;
        end else if (pad != 2'd0) begin
          pad_left_next = pad - 2'd1;
        end else if (bip != 2'd3) begin
          pixel_accum_next = acc | (24'(b) << {bip, 3'b000});
          byte_in_pixel_next = bip + 2'd1;
          if (bip == 2'd2 && !bpp4) begin
            emit = 1'b1;
            emit_acc = pixel_accum_next;
          end
        end else begin
          emit = 1'b1;
          emit_alpha = b;
        end
        if (emit) begin
          push = 1'b1;
          res.status = bsp_pkg::ST_PIXEL;
          res.x = col;
          res.y = h - DIM_W'(1) - rw;
          res.red = emit_acc[23:16];
          res.green = emit_acc[15:8];
          res.blue = emit_acc[7:0];
          res.alpha = emit_alpha;
          res.last = (rw == h - DIM_W'(1)) && (col == w - DIM_W'(1));
          pixel_accum_next = '0;
          byte_in_pixel_next = '0;
          if (col == w - DIM_W'(1)) begin
            column_next = '0;
            row_next = rw + DIM_W'(1);
            pad_left_next = bpp4 ? 2'd0 : w[1:0];
            if (rw == h - DIM_W'(1)) begin
              phase_next = bsp_pkg::PH_DONE;
            end
          end else begin
            column_next = col + DIM_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= bsp_pkg::PH_HEADER;
      byte_count <= '0;
      file_size <= '0;
      dib_size <= '0;
      dib_big <= 1'b0;
      image_width <= '0;
      width_big <= 1'b0;
      image_height <= '0;
      height_big <= 1'b0;
      bit_depth <= '0;
      comp_nonzero <= 1'b0;
      pixel_accum <= '0;
      byte_in_pixel <= '0;
      column <= '0;
      row <= '0;
      pad_left <= '0;
    end else if (accept) begin
      phase <= phase_next;
      byte_count <= byte_count_next;
      file_size <= file_size_next;
      dib_size <= dib_size_next;
      dib_big <= dib_big_next;
      image_width <= image_width_next;
      width_big <= width_big_next;
      image_height <= image_height_next;
      height_big <= height_big_next;
      bit_depth <= bit_depth_next;
      comp_nonzero <= comp_nonzero_next;
      pixel_accum <= pixel_accum_next;
      byte_in_pixel <= byte_in_pixel_next;
      column <= column_next;
      row <= row_next;
      pad_left <= pad_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (accept && push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'((accept && push) ? 1 : 0) - 2'(pop ? 1 : 0);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && push) begin
      queue[wr_ptr] <= res;
    end
  end

  assign status = queue[rd_ptr].status;
  assign pixel_x = COORD_WIDTH'(queue[rd_ptr].x);
  assign pixel_y = COORD_WIDTH'(queue[rd_ptr].y);
  assign red = queue[rd_ptr].red;
  assign green = queue[rd_ptr].green;
  assign blue = queue[rd_ptr].blue;
  assign alpha = queue[rd_ptr].alpha;
  assign last_pixel = queue[rd_ptr].last;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("Result queue holds more than two items.");

  a_error_ends_file: assert property (@(posedge clk) disable iff (rst)
    (accept && push && res.status != bsp_pkg::ST_PIXEL) |=> (phase == bsp_pkg::PH_DONE))
    else $error("Parser keeps running after reporting an error.");

  a_last_ends_file: assert property (@(posedge clk) disable iff (rst)
    (accept && push && res.last) |=> (phase == bsp_pkg::PH_DONE))
    else $error("Parser keeps running after the last pixel.");

  a_pixel_depth: assert property (@(posedge clk) disable iff (rst)
    (phase == bsp_pkg::PH_PIXELS)
      |-> (bit_depth == bsp_pkg::DEPTH_24 || bit_depth == bsp_pkg::DEPTH_32))
    else $error("Pixel phase entered with an unsupported bit depth.");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !(accept && push)) |=> (count == $past(count) - 2'd1))
    else $error("Result queue count does not drop on a lone pop.");

endmodule
